@@ design/stack_machine_cpu_core_assert.svh @@
// assertion macros for the stack machine core
`ifndef STACK_MACHINE_CPU_CORE_ASSERT_SVH
`define STACK_MACHINE_CPU_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SMC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smc assertion failed");

// consequent holds in the cycle after the antecedent
`define SMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smc assertion failed");

`endif

@@ design/smc_pkg.sv @@
// types, codes and decode helpers of the stack machine core
package smc_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_DEV  = 2'd1;
   localparam logic [1:0] REQ_PC   = 2'd2;
   localparam logic [1:0] REQ_STEP = 2'd3;

   // stop status codes
   localparam logic [1:0] STOP_NONE  = 2'd0;
   localparam logic [1:0] STOP_BRK   = 2'd1;
   localparam logic [1:0] STOP_LIMIT = 2'd2;

   // full instruction bytes with immediate forms
   localparam logic [7:0] INS_BRK   = 8'h00;
   localparam logic [7:0] INS_JCI   = 8'h20;
   localparam logic [7:0] INS_JMI   = 8'h40;
   localparam logic [7:0] INS_JSI   = 8'h60;
   localparam logic [7:0] INS_LIT   = 8'h80;
   localparam logic [7:0] INS_LIT2  = 8'ha0;
   localparam logic [7:0] INS_LITR  = 8'hc0;
   localparam logic [7:0] INS_LIT2R = 8'he0;

   // base opcodes
   localparam logic [4:0] OP_INC = 5'h01;
   localparam logic [4:0] OP_POP = 5'h02;
   localparam logic [4:0] OP_NIP = 5'h03;
   localparam logic [4:0] OP_SWP = 5'h04;
   localparam logic [4:0] OP_ROT = 5'h05;
   localparam logic [4:0] OP_DUP = 5'h06;
   localparam logic [4:0] OP_OVR = 5'h07;
   localparam logic [4:0] OP_EQU = 5'h08;
   localparam logic [4:0] OP_NEQ = 5'h09;
   localparam logic [4:0] OP_GTH = 5'h0a;
   localparam logic [4:0] OP_LTH = 5'h0b;
   localparam logic [4:0] OP_JMP = 5'h0c;
   localparam logic [4:0] OP_JCN = 5'h0d;
   localparam logic [4:0] OP_JSR = 5'h0e;
   localparam logic [4:0] OP_STH = 5'h0f;
   localparam logic [4:0] OP_LDZ = 5'h10;
   localparam logic [4:0] OP_STZ = 5'h11;
   localparam logic [4:0] OP_LDR = 5'h12;
   localparam logic [4:0] OP_STR = 5'h13;
   localparam logic [4:0] OP_LDA = 5'h14;
   localparam logic [4:0] OP_STA = 5'h15;
   localparam logic [4:0] OP_DEI = 5'h16;
   localparam logic [4:0] OP_DEO = 5'h17;
   localparam logic [4:0] OP_ADD = 5'h18;
   localparam logic [4:0] OP_SUB = 5'h19;
   localparam logic [4:0] OP_MUL = 5'h1a;
   localparam logic [4:0] OP_DIV = 5'h1b;
   localparam logic [4:0] OP_AND = 5'h1c;
   localparam logic [4:0] OP_ORA = 5'h1d;
   localparam logic [4:0] OP_EOR = 5'h1e;
   localparam logic [4:0] OP_SFT = 5'h1f;

   // byte counts popped into operands a, b and c
   typedef struct packed {
      logic [1:0] na;
      logic [1:0] nb;
      logic [1:0] nc;
   } pop_plan_type;

   function automatic pop_plan_type pop_plan(input logic [4:0] op, input logic sm);
      logic [1:0]   nv;
      pop_plan_type p;
      nv   = sm ? 2'd2 : 2'd1;
      p.na = nv;
      p.nb = nv;
      p.nc = 2'd0;
      case (op) inside
         OP_LDZ, OP_LDR, OP_DEI: begin
            p.na = 2'd1;
            p.nb = 2'd0;
         end
         OP_STZ, OP_STR, OP_DEO, OP_SFT: begin
            p.na = 2'd1;
         end
         OP_LDA: begin
            p.na = 2'd2;
            p.nb = 2'd0;
         end
         OP_STA: begin
            p.na = 2'd2;
         end
         OP_JCN: begin
            p.nb = 2'd1;
         end
         OP_ROT: begin
            p.nc = nv;
         end
         OP_INC, OP_POP, OP_DUP, OP_JMP, OP_JSR, OP_STH: begin
            p.nb = 2'd0;
         end
         default: begin
         end
      endcase
      return p;
   endfunction

endpackage

@@ design/stack_machine_cpu_core.sv @@
// stack machine core: two byte stacks, 64 KiB memory, device page, one instruction per step
//
// Input channel req_*: one transaction per host request (load memory byte, set device
// byte, set start pc, step). Result channel rsp_*: exactly one transaction per request,
// in order. Config channel csr_*: writes the step limit, always ready.
// Every request ends in the DONE state, which hands its result to the rsp register. A step
// fetches and decodes the opcode, pops each byte through POP_RD and POP_CAP, reads each
// memory byte through MRD and MCAP, pushes each byte in PUSH, and for DIV also runs a
// bit-serial restoring divider. The byte-wide memory and stack ports set this sequence.
// One request is in flight at a time; req_ready is high only while the sequencer idles.
// A finished result waits in the rsp register; the next request is accepted meanwhile,
// and its result is held until the receiver takes the older one.
// After reset a clearing pass zeroes main memory, the device page and both stacks, one
// entry a cycle; no request is accepted during it.
`include "stack_machine_cpu_core_assert.svh"

module stack_machine_cpu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_location,
   input  logic [7:0]  req_port_number,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_stop_status,
   output logic        rsp_dev_out_valid,
   output logic [7:0]  rsp_dev_out_port,
   output logic [7:0]  rsp_dev_out_byte,
   output logic [15:0] rsp_next_pc,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_FETCH   = 4'd2;
   localparam logic [3:0] ST_DECODE  = 4'd3;
   localparam logic [3:0] ST_POP_RD  = 4'd4;
   localparam logic [3:0] ST_POP_CAP = 4'd5;
   localparam logic [3:0] ST_EXEC    = 4'd6;
   localparam logic [3:0] ST_DIV     = 4'd7;
   localparam logic [3:0] ST_MRD     = 4'd8;
   localparam logic [3:0] ST_MCAP    = 4'd9;
   localparam logic [3:0] ST_MDONE   = 4'd10;
   localparam logic [3:0] ST_MWR     = 4'd11;
   localparam logic [3:0] ST_JRD     = 4'd12;
   localparam logic [3:0] ST_JCAP    = 4'd13;
   localparam logic [3:0] ST_PUSH    = 4'd14;
   localparam logic [3:0] ST_DONE    = 4'd15;

   // control registers
   logic [3:0]  state_ff, state_in;
   logic [15:0] clr_ff, clr_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  wtop_ff, wtop_in;
   logic [7:0]  rtop_ff, rtop_in;
   logic [31:0] step_cnt_ff, step_cnt_in;
   logic [31:0] limit_ff, limit_in;
   logic [1:0]  st_ff, st_in;
   logic        ev_ff, ev_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [7:0]  ins_ff, ins_in;
   logic [15:0] a_ff, a_in;
   logic [15:0] b_ff, b_in;
   logic [15:0] c_ff, c_in;
   logic [15:0] t_ff, t_in;
   logic [7:0]  cur_ff, cur_in;
   smc_pkg::pop_plan_type plan_ff, plan_in;
   logic [1:0]  pop_sel_ff, pop_sel_in;
   logic        pop_hi_ff, pop_hi_in;
   logic [15:0] maddr_ff, maddr_in;
   logic        zp_ff, zp_in;
   logic        dev_ff, dev_in;
   logic        rd16_ff, rd16_in;
   logic        mphase_ff, mphase_in;
   logic [15:0] p0_ff, p0_in;
   logic [15:0] p1_ff, p1_in;
   logic [15:0] p2_ff, p2_in;
   logic [1:0]  psh_n_ff, psh_n_in;
   logic [1:0]  psh_idx_ff, psh_idx_in;
   logic        psh_hi_ff, psh_hi_in;
   logic        psh_sm_ff, psh_sm_in;
   logic        psh_rs_ff, psh_rs_in;
   logic [15:0] div_rem_ff, div_rem_in;
   logic [15:0] div_quo_ff, div_quo_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   logic [7:0]  evp_ff, evp_in;
   logic [7:0]  evb_ff, evb_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_ev_ff, rsp_ev_in;
   logic [7:0]  rsp_evp_ff, rsp_evp_in;
   logic [7:0]  rsp_evb_ff, rsp_evb_in;
   logic [15:0] rsp_pc_ff, rsp_pc_in;

   // memories and their ports
   logic [7:0]  main_mem [65536];
   logic [7:0]  dev_page [256];
   logic [7:0]  wstk [256];
   logic [7:0]  rstk [256];
   logic [7:0]  mem_q_ff, dev_q_ff, ws_q_ff, rs_q_ff;
   logic        mem_we, dev_we, ws_we, rs_we;
   logic [15:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata;
   logic [7:0]  dev_waddr, dev_raddr, dev_wdata;
   logic [7:0]  stk_waddr, stk_raddr, stk_wdata;

   // decode and datapath signals
   logic [4:0]  op;
   logic        sm, rm, km;
   logic [15:0] maddr2, m_addr_cur;
   logic [15:0] rel_tgt, jmp_tgt;
   logic [31:0] mul_full;
   logic [15:0] alu_res;
   logic [16:0] div_shift, div_sub;
   logic        div_ge;
   logic [15:0] div_rem_nx, div_quo_nx;
   logic [15:0] psh_cur;
   logic [7:0]  psh_byte;
   logic [1:0]  pop_need, next_need;
   logic [7:0]  stk_q, rd_q;
   logic        limit_hit;

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stop_status   = rsp_status_ff;
   assign rsp_dev_out_valid = rsp_ev_ff;
   assign rsp_dev_out_port  = rsp_evp_ff;
   assign rsp_dev_out_byte  = rsp_evb_ff;
   assign rsp_next_pc       = rsp_pc_ff;

   assign op = ins_ff[4:0];
   assign sm = ins_ff[5];
   assign rm = ins_ff[6];
   assign km = ins_ff[7];

   // address helpers
   assign maddr2     = zp_ff ? {8'h00, maddr_ff[7:0] + 8'd1} : maddr_ff + 16'd1;
   assign m_addr_cur = mphase_ff ? maddr2 : maddr_ff;
   assign rel_tgt    = pc_ff + {{8{a_ff[7]}}, a_ff[7:0]};
   assign jmp_tgt    = sm ? a_ff : rel_tgt;
   assign limit_hit  = (limit_ff != 32'd0) && (step_cnt_ff >= limit_ff);

   // shared arithmetic, compare and shift unit
   assign mul_full = b_ff * a_ff;
   always_comb begin
      case (op) inside
         smc_pkg::OP_INC: alu_res = a_ff + 16'd1;
         smc_pkg::OP_ADD: alu_res = b_ff + a_ff;
         smc_pkg::OP_SUB: alu_res = b_ff - a_ff;
         smc_pkg::OP_MUL: alu_res = mul_full[15:0];
         smc_pkg::OP_AND: alu_res = b_ff & a_ff;
         smc_pkg::OP_ORA: alu_res = b_ff | a_ff;
         smc_pkg::OP_EOR: alu_res = b_ff ^ a_ff;
         smc_pkg::OP_SFT: alu_res = (b_ff >> a_ff[3:0]) << a_ff[7:4];
         smc_pkg::OP_EQU: alu_res = {15'd0, b_ff == a_ff};
         smc_pkg::OP_NEQ: alu_res = {15'd0, b_ff != a_ff};
         smc_pkg::OP_GTH: alu_res = {15'd0, b_ff > a_ff};
         smc_pkg::OP_LTH: alu_res = {15'd0, b_ff < a_ff};
         default:         alu_res = a_ff;
      endcase
   end

   // one restoring divide step
   assign div_shift  = {div_rem_ff, div_quo_ff[15]};
   assign div_ge     = (div_shift >= {1'b0, a_ff});
   assign div_sub    = div_shift - {1'b0, a_ff};
   assign div_rem_nx = div_ge ? div_sub[15:0] : div_shift[15:0];
   assign div_quo_nx = {div_quo_ff[14:0], div_ge};

   // push value and byte selection
   always_comb begin
      case (psh_idx_ff)
         2'd0:    psh_cur = p0_ff;
         2'd1:    psh_cur = p1_ff;
         default: psh_cur = p2_ff;
      endcase
   end
   assign psh_byte = (psh_sm_ff && !psh_hi_ff) ? psh_cur[15:8] : psh_cur[7:0];

   // pop sizing for the operand being filled
   always_comb begin
      case (pop_sel_ff)
         2'd0: begin
            pop_need  = plan_ff.na;
            next_need = plan_ff.nb;
         end
         2'd1: begin
            pop_need  = plan_ff.nb;
            next_need = plan_ff.nc;
         end
         default: begin
            pop_need  = plan_ff.nc;
            next_need = 2'd0;
         end
      endcase
   end

   assign stk_q     = rm ? rs_q_ff : ws_q_ff;
   assign rd_q      = dev_ff ? dev_q_ff : mem_q_ff;
   assign stk_raddr = (state_ff == ST_JRD) ? wtop_ff : cur_ff - 8'd1;
   assign dev_raddr = m_addr_cur[7:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pc_in         = pc_ff;
      wtop_in       = wtop_ff;
      rtop_in       = rtop_ff;
      step_cnt_in   = step_cnt_ff;
      limit_in      = limit_ff;
      st_in         = st_ff;
      ev_in         = ev_ff;
      rsp_valid_in  = rsp_valid_ff;
      ins_in        = ins_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      t_in          = t_ff;
      cur_in        = cur_ff;
      plan_in       = plan_ff;
      pop_sel_in    = pop_sel_ff;
      pop_hi_in     = pop_hi_ff;
      maddr_in      = maddr_ff;
      zp_in         = zp_ff;
      dev_in        = dev_ff;
      rd16_in       = rd16_ff;
      mphase_in     = mphase_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      psh_n_in      = psh_n_ff;
      psh_idx_in    = psh_idx_ff;
      psh_hi_in     = psh_hi_ff;
      psh_sm_in     = psh_sm_ff;
      psh_rs_in     = psh_rs_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      evp_in        = evp_ff;
      evb_in        = evb_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evp_in    = rsp_evp_ff;
      rsp_evb_in    = rsp_evb_ff;
      rsp_pc_in     = rsp_pc_ff;
      mem_we        = 1'b0;
      mem_waddr     = m_addr_cur;
      mem_wdata     = 8'd0;
      mem_raddr     = pc_ff;
      dev_we        = 1'b0;
      dev_waddr     = m_addr_cur[7:0];
      dev_wdata     = 8'd0;
      ws_we         = 1'b0;
      rs_we         = 1'b0;
      stk_waddr     = psh_rs_ff ? rtop_ff : wtop_ff;
      stk_wdata     = psh_byte;

      // config write
      if (csr_valid) begin
         limit_in = csr_data;
      end

      // result taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            dev_we    = 1'b1;
            dev_waddr = clr_ff[7:0];
            ws_we     = 1'b1;
            rs_we     = 1'b1;
            stk_waddr = clr_ff[7:0];
            stk_wdata = 8'd0;
            clr_in    = clr_ff + 16'd1;
            if (clr_ff == 16'hffff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               st_in    = smc_pkg::STOP_NONE;
               ev_in    = 1'b0;
               evp_in   = 8'd0;
               evb_in   = 8'd0;
               state_in = ST_DONE;
               unique case (req_type)
                  smc_pkg::REQ_LOAD: begin
                     mem_we    = 1'b1;
                     mem_waddr = req_location;
                     mem_wdata = req_byte_in;
                  end
                  smc_pkg::REQ_DEV: begin
                     dev_we    = 1'b1;
                     dev_waddr = req_port_number;
                     dev_wdata = req_byte_in;
                  end
                  smc_pkg::REQ_PC: begin
                     pc_in       = req_location;
                     step_cnt_in = 32'd0;
                  end
                  default: begin
                     if (limit_hit) begin
                        st_in = smc_pkg::STOP_LIMIT;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            ins_in      = mem_q_ff;
            pc_in       = pc_ff + 16'd1;
            step_cnt_in = step_cnt_ff + 32'd1;
            if (mem_q_ff == smc_pkg::INS_BRK) begin
               st_in    = smc_pkg::STOP_BRK;
               state_in = ST_DONE;
            end else if (mem_q_ff[4:0] == 5'd0) begin
               // immediate operand follows the opcode byte
               maddr_in  = pc_ff + 16'd1;
               zp_in     = 1'b0;
               dev_in    = 1'b0;
               rd16_in   = !(mem_q_ff[7] && !mem_q_ff[5]);
               mphase_in = 1'b0;
               state_in  = ST_MRD;
            end else begin
               plan_in    = smc_pkg::pop_plan(mem_q_ff[4:0], mem_q_ff[5]);
               cur_in     = mem_q_ff[6] ? rtop_ff : wtop_ff;
               a_in       = 16'd0;
               b_in       = 16'd0;
               c_in       = 16'd0;
               pop_sel_in = 2'd0;
               pop_hi_in  = 1'b0;
               state_in   = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            cur_in   = cur_ff - 8'd1;
            state_in = ST_POP_CAP;
         end
         ST_POP_CAP: begin
            // first byte popped is the low byte
            case (pop_sel_ff)
               2'd0: begin
                  if (pop_hi_ff) a_in[15:8] = stk_q;
                  else           a_in[7:0]  = stk_q;
               end
               2'd1: begin
                  if (pop_hi_ff) b_in[15:8] = stk_q;
                  else           b_in[7:0]  = stk_q;
               end
               default: begin
                  if (pop_hi_ff) c_in[15:8] = stk_q;
                  else           c_in[7:0]  = stk_q;
               end
            endcase
            if (!pop_hi_ff && pop_need == 2'd2) begin
               pop_hi_in = 1'b1;
               state_in  = ST_POP_RD;
            end else begin
               pop_hi_in = 1'b0;
               if (pop_sel_ff != 2'd2 && next_need != 2'd0) begin
                  pop_sel_in = pop_sel_ff + 2'd1;
                  state_in   = ST_POP_RD;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            // keep mode leaves the source pointer where it was
            if (!km) begin
               if (rm) rtop_in = cur_ff;
               else    wtop_in = cur_ff;
            end
            psh_idx_in = 2'd0;
            psh_hi_in  = 1'b0;
            psh_sm_in  = sm;
            psh_rs_in  = rm;
            psh_n_in   = 2'd1;
            state_in   = ST_PUSH;
            case (op) inside
               smc_pkg::OP_INC, smc_pkg::OP_NIP, smc_pkg::OP_ADD, smc_pkg::OP_SUB,
               smc_pkg::OP_MUL, smc_pkg::OP_AND, smc_pkg::OP_ORA, smc_pkg::OP_EOR,
               smc_pkg::OP_SFT: begin
                  p0_in = alu_res;
               end
               smc_pkg::OP_EQU, smc_pkg::OP_NEQ, smc_pkg::OP_GTH, smc_pkg::OP_LTH: begin
                  p0_in     = alu_res;
                  psh_sm_in = 1'b0;
               end
               smc_pkg::OP_SWP: begin
                  p0_in    = a_ff;
                  p1_in    = b_ff;
                  psh_n_in = 2'd2;
               end
               smc_pkg::OP_ROT: begin
                  p0_in    = b_ff;
                  p1_in    = a_ff;
                  p2_in    = c_ff;
                  psh_n_in = 2'd3;
               end
               smc_pkg::OP_DUP: begin
                  p0_in    = a_ff;
                  p1_in    = a_ff;
                  psh_n_in = 2'd2;
               end
               smc_pkg::OP_OVR: begin
                  p0_in    = b_ff;
                  p1_in    = a_ff;
                  p2_in    = b_ff;
                  psh_n_in = 2'd3;
               end
               smc_pkg::OP_JMP: begin
                  pc_in    = jmp_tgt;
                  state_in = ST_DONE;
               end
               smc_pkg::OP_JCN: begin
                  if (b_ff != 16'd0) pc_in = jmp_tgt;
                  state_in = ST_DONE;
               end
               smc_pkg::OP_JSR: begin
                  p0_in     = pc_ff;
                  psh_sm_in = 1'b1;
                  psh_rs_in = !rm;
                  pc_in     = jmp_tgt;
               end
               smc_pkg::OP_STH: begin
                  p0_in     = a_ff;
                  psh_rs_in = !rm;
               end
               smc_pkg::OP_LDZ, smc_pkg::OP_STZ: begin
                  maddr_in  = {8'h00, a_ff[7:0]};
                  zp_in     = 1'b1;
                  dev_in    = 1'b0;
                  rd16_in   = sm;
                  mphase_in = 1'b0;
                  state_in  = (op == smc_pkg::OP_LDZ) ? ST_MRD : ST_MWR;
               end
               smc_pkg::OP_LDR, smc_pkg::OP_STR: begin
                  maddr_in  = rel_tgt;
                  zp_in     = 1'b0;
                  dev_in    = 1'b0;
                  rd16_in   = sm;
                  mphase_in = 1'b0;
                  state_in  = (op == smc_pkg::OP_LDR) ? ST_MRD : ST_MWR;
               end
               smc_pkg::OP_LDA, smc_pkg::OP_STA: begin
                  maddr_in  = a_ff;
                  zp_in     = 1'b0;
                  dev_in    = 1'b0;
                  rd16_in   = sm;
                  mphase_in = 1'b0;
                  state_in  = (op == smc_pkg::OP_LDA) ? ST_MRD : ST_MWR;
               end
               smc_pkg::OP_DEI: begin
                  maddr_in  = {8'h00, a_ff[7:0]};
                  zp_in     = 1'b1;
                  dev_in    = 1'b1;
                  rd16_in   = sm;
                  mphase_in = 1'b0;
                  state_in  = ST_MRD;
               end
               smc_pkg::OP_DEO: begin
                  // only the last byte written is reported
                  maddr_in  = {8'h00, a_ff[7:0]};
                  zp_in     = 1'b1;
                  dev_in    = 1'b1;
                  rd16_in   = sm;
                  mphase_in = 1'b0;
                  ev_in     = 1'b1;
                  evp_in    = sm ? a_ff[7:0] + 8'd1 : a_ff[7:0];
                  evb_in    = b_ff[7:0];
                  state_in  = ST_MWR;
               end
               smc_pkg::OP_DIV: begin
                  if (a_ff == 16'd0) begin
                     p0_in = 16'd0;
                  end else begin
                     div_rem_in = 16'd0;
                     div_quo_in = b_ff;
                     div_cnt_in = 4'd0;
                     state_in   = ST_DIV;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DIV: begin
            div_rem_in = div_rem_nx;
            div_quo_in = div_quo_nx;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               p0_in    = div_quo_nx;
               state_in = ST_PUSH;
            end
         end
         ST_MRD: begin
            mem_raddr = m_addr_cur;
            state_in  = ST_MCAP;
         end
         ST_MCAP: begin
            // high byte sits at the lower address
            if (!mphase_ff) begin
               if (rd16_ff) begin
                  t_in[15:8] = rd_q;
                  mphase_in  = 1'b1;
                  state_in   = ST_MRD;
               end else begin
                  t_in     = {8'h00, rd_q};
                  state_in = ST_MDONE;
               end
            end else begin
               t_in[7:0] = rd_q;
               state_in  = ST_MDONE;
            end
         end
         ST_MDONE: begin
            psh_idx_in = 2'd0;
            psh_hi_in  = 1'b0;
            psh_n_in   = 2'd1;
            p0_in      = t_ff;
            state_in   = ST_PUSH;
            case (ins_ff) inside
               smc_pkg::INS_JCI: begin
                  pc_in    = pc_ff + 16'd2;
                  a_in     = t_ff;
                  wtop_in  = wtop_ff - 8'd1;
                  state_in = ST_JRD;
               end
               smc_pkg::INS_JMI: begin
                  pc_in    = pc_ff + 16'd2 + t_ff;
                  state_in = ST_DONE;
               end
               smc_pkg::INS_JSI: begin
                  p0_in     = pc_ff + 16'd2;
                  pc_in     = pc_ff + 16'd2 + t_ff;
                  psh_sm_in = 1'b1;
                  psh_rs_in = 1'b1;
               end
               smc_pkg::INS_LIT, smc_pkg::INS_LITR: begin
                  pc_in     = pc_ff + 16'd1;
                  psh_sm_in = 1'b0;
                  psh_rs_in = rm;
               end
               smc_pkg::INS_LIT2, smc_pkg::INS_LIT2R: begin
                  pc_in     = pc_ff + 16'd2;
                  psh_sm_in = 1'b1;
                  psh_rs_in = rm;
               end
               default: begin
                  psh_sm_in = sm;
                  psh_rs_in = rm;
               end
            endcase
         end
         ST_MWR: begin
            if (dev_ff) begin
               dev_we    = 1'b1;
               dev_wdata = (rd16_ff && !mphase_ff) ? b_ff[15:8] : b_ff[7:0];
            end else begin
               mem_we    = 1'b1;
               mem_wdata = (rd16_ff && !mphase_ff) ? b_ff[15:8] : b_ff[7:0];
            end
            if (rd16_ff && !mphase_ff) begin
               mphase_in = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_JRD: begin
            state_in = ST_JCAP;
         end
         ST_JCAP: begin
            if (ws_q_ff != 8'd0) pc_in = pc_ff + a_ff;
            state_in = ST_DONE;
         end
         ST_PUSH: begin
            if (psh_rs_ff) begin
               rs_we   = 1'b1;
               rtop_in = rtop_ff + 8'd1;
            end else begin
               ws_we   = 1'b1;
               wtop_in = wtop_ff + 8'd1;
            end
            if (psh_sm_ff && !psh_hi_ff) begin
               psh_hi_in = 1'b1;
            end else begin
               psh_hi_in  = 1'b0;
               psh_idx_in = psh_idx_ff + 2'd1;
               if (psh_idx_ff == psh_n_ff - 2'd1) begin
                  state_in = ST_DONE;
               end
            end
         end
         default: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_ev_in     = ev_ff;
               rsp_evp_in    = evp_ff;
               rsp_evb_in    = evb_ff;
               rsp_pc_in     = pc_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= 16'd0;
         pc_ff        <= 16'd0;
         wtop_ff      <= 8'd0;
         rtop_ff      <= 8'd0;
         step_cnt_ff  <= 32'd0;
         limit_ff     <= 32'd0;
         st_ff        <= smc_pkg::STOP_NONE;
         ev_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         wtop_ff      <= wtop_in;
         rtop_ff      <= rtop_in;
         step_cnt_ff  <= step_cnt_in;
         limit_ff     <= limit_in;
         st_ff        <= st_in;
         ev_ff        <= ev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ins_ff        <= ins_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      t_ff          <= t_in;
      cur_ff        <= cur_in;
      plan_ff       <= plan_in;
      pop_sel_ff    <= pop_sel_in;
      pop_hi_ff     <= pop_hi_in;
      maddr_ff      <= maddr_in;
      zp_ff         <= zp_in;
      dev_ff        <= dev_in;
      rd16_ff       <= rd16_in;
      mphase_ff     <= mphase_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      psh_n_ff      <= psh_n_in;
      psh_idx_ff    <= psh_idx_in;
      psh_hi_ff     <= psh_hi_in;
      psh_sm_ff     <= psh_sm_in;
      psh_rs_ff     <= psh_rs_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_cnt_ff    <= div_cnt_in;
      evp_ff        <= evp_in;
      evb_ff        <= evb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evp_ff    <= rsp_evp_in;
      rsp_evb_ff    <= rsp_evb_in;
      rsp_pc_ff     <= rsp_pc_in;
   end

   // main memory
   always_ff @(posedge clock) begin
      if (mem_we) main_mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= main_mem[mem_raddr];
   end

   // device page
   always_ff @(posedge clock) begin
      if (dev_we) dev_page[dev_waddr] <= dev_wdata;
      dev_q_ff <= dev_page[dev_raddr];
   end

   // work stack
   always_ff @(posedge clock) begin
      if (ws_we) wstk[stk_waddr] <= stk_wdata;
      ws_q_ff <= wstk[stk_raddr];
   end

   // return stack
   always_ff @(posedge clock) begin
      if (rs_we) rstk[stk_waddr] <= stk_wdata;
      rs_q_ff <= rstk[stk_raddr];
   end

   // checks
   `SMC_ASSERT_NEXT(a_limit_stop, clock, reset,
      req_valid && req_ready && req_type == smc_pkg::REQ_STEP && limit_hit,
      state_ff == ST_DONE && st_ff == smc_pkg::STOP_LIMIT)
   `SMC_ASSERT_SAME(a_div_nonzero, clock, reset, state_ff == ST_DIV, a_ff != 16'd0)
   `SMC_ASSERT_SAME(a_event_deo, clock, reset, state_ff == ST_DONE && ev_ff,
      ins_ff[4:0] == smc_pkg::OP_DEO)

endmodule

@@ bench/stack_machine_cpu_core_tb.sv @@
// testbench of the stack machine core: scoreboard with its own cpu model and random programs
module stack_machine_cpu_core_tb;
   import smc_pkg::*;

   typedef struct {
      bit [1:0]  stop;
      bit        dv;
      bit [7:0]  dp;
      bit [7:0]  db;
      bit [15:0] pc;
   } cpu_result_t;

   // cpu model and the queue of results it expects
   class cpu_scoreboard;
      bit [7:0]    mem [0:65535];
      bit [7:0]    dev [0:255];
      bit [7:0]    stk [2][0:255];
      bit [7:0]    sp [2];
      bit [15:0]   pc;
      bit [31:0]   count;
      bit [31:0]   limit;
      bit [7:0]    cur;
      int          s_src;
      cpu_result_t awaited[$];
      int          errors, n_checked, n_brk, n_limit, n_dev;

      function bit [7:0] pop_byte();
         cur--;
         return stk[s_src][cur];
      endfunction

      function bit [15:0] pop_word();
         bit [7:0] lo, hi;
         lo = pop_byte();
         hi = pop_byte();
         return {hi, lo};
      endfunction

      function bit [15:0] pop_val(bit sm);
         bit [15:0] v;
         if (sm) v = pop_word();
         else v = {8'h00, pop_byte()};
         return v;
      endfunction

      function void push_byte(int s, bit [7:0] v);
         stk[s][sp[s]] = v;
         sp[s]++;
      endfunction

      function void push_val(int s, bit [15:0] v, bit sm);
         if (sm) push_byte(s, v[15:8]);
         push_byte(s, v[7:0]);
      endfunction

      // zero page accesses wrap the second byte within the page
      function bit [15:0] mem_word(bit [15:0] a, bit zp);
         bit [15:0] a2;
         a2 = zp ? {8'h00, a[7:0] + 8'd1} : a + 16'd1;
         return {mem[a], mem[a2]};
      endfunction

      function void mem_write(bit [15:0] a, bit [15:0] v, bit sm, bit zp);
         bit [15:0] a2;
         a2 = zp ? {8'h00, a[7:0] + 8'd1} : a + 16'd1;
         if (sm) begin
            mem[a]  = v[15:8];
            mem[a2] = v[7:0];
         end else begin
            mem[a] = v[7:0];
         end
      endfunction

      function bit [15:0] rel_pc(bit [15:0] p, bit [15:0] off);
         return p + {{8{off[7]}}, off[7:0]};
      endfunction

      // one instruction at pc
      function void execute(ref cpu_result_t r);
         bit [7:0]  ins;
         bit [15:0] a, b, c, p;
         bit [4:0]  op;
         bit        sm, km;
         int        src, oth;
         bit [31:0] v;
         ins = mem[pc];
         p = pc + 16'd1;
         count++;
         a = 0; b = 0; c = 0;
         case (ins)
            INS_BRK: r.stop = STOP_BRK;
            INS_JCI: begin
               a = mem_word(p, 0);
               p = p + 16'd2;
               sp[0]--;
               if (stk[0][sp[0]] != 0) p = p + a;
            end
            INS_JMI: begin
               a = mem_word(p, 0);
               p = p + 16'd2 + a;
            end
            INS_JSI: begin
               a = mem_word(p, 0);
               p = p + 16'd2;
               push_val(1, p, 1);
               p = p + a;
            end
            INS_LIT, INS_LITR: begin
               push_byte(ins == INS_LIT ? 0 : 1, mem[p]);
               p = p + 16'd1;
            end
            INS_LIT2, INS_LIT2R: begin
               push_val(ins == INS_LIT2 ? 0 : 1, mem_word(p, 0), 1);
               p = p + 16'd2;
            end
            default: begin
               op = ins[4:0];
               sm = ins[5];
               km = ins[7];
               src = ins[6];
               oth = 1 - src;
               s_src = src;
               cur = sp[src];
               // operand pops
               case (op)
                  OP_LDZ, OP_LDR, OP_DEI: a = pop_byte();
                  OP_STZ, OP_STR, OP_DEO, OP_SFT: begin
                     a = pop_byte();
                     b = pop_val(sm);
                  end
                  OP_LDA: a = pop_word();
                  OP_STA: begin
                     a = pop_word();
                     b = pop_val(sm);
                  end
                  OP_JCN: begin
                     a = pop_val(sm);
                     b = pop_byte();
                  end
                  OP_ROT: begin
                     a = pop_val(sm);
                     b = pop_val(sm);
                     c = pop_val(sm);
                  end
                  OP_INC, OP_POP, OP_DUP, OP_JMP, OP_JSR, OP_STH: a = pop_val(sm);
                  default: begin
                     a = pop_val(sm);
                     b = pop_val(sm);
                  end
               endcase
               if (!km) sp[src] = cur;
               case (op)
                  OP_INC: push_val(src, a + 16'd1, sm);
                  OP_POP: ;
                  OP_NIP: push_val(src, a, sm);
                  OP_SWP: begin
                     push_val(src, a, sm);
                     push_val(src, b, sm);
                  end
                  OP_ROT: begin
                     push_val(src, b, sm);
                     push_val(src, a, sm);
                     push_val(src, c, sm);
                  end
                  OP_DUP: begin
                     push_val(src, a, sm);
                     push_val(src, a, sm);
                  end
                  OP_OVR: begin
                     push_val(src, b, sm);
                     push_val(src, a, sm);
                     push_val(src, b, sm);
                  end
                  OP_EQU: push_byte(src, {7'd0, b == a});
                  OP_NEQ: push_byte(src, {7'd0, b != a});
                  OP_GTH: push_byte(src, {7'd0, b > a});
                  OP_LTH: push_byte(src, {7'd0, b < a});
                  OP_JMP: p = sm ? a : rel_pc(p, a);
                  OP_JCN: if (b != 0) p = sm ? a : rel_pc(p, a);
                  OP_JSR: begin
                     push_val(oth, p, 1);
                     p = sm ? a : rel_pc(p, a);
                  end
                  OP_STH: push_val(oth, a, sm);
                  OP_LDZ: push_val(src, sm ? mem_word(a, 1) : {8'h00, mem[a]}, sm);
                  OP_STZ: mem_write(a, b, sm, 1);
                  OP_LDR: begin
                     b = rel_pc(p, a);
                     push_val(src, sm ? mem_word(b, 0) : {8'h00, mem[b]}, sm);
                  end
                  OP_STR: mem_write(rel_pc(p, a), b, sm, 0);
                  OP_LDA: push_val(src, sm ? mem_word(a, 0) : {8'h00, mem[a]}, sm);
                  OP_STA: mem_write(a, b, sm, 0);
                  OP_DEI: begin
                     b = {8'h00, dev[a[7:0]]};
                     if (sm) b = {b[7:0], dev[a[7:0] + 8'd1]};
                     push_val(src, b, sm);
                  end
                  // short write: high byte lands silently, low byte is the event
                  OP_DEO: begin
                     if (sm) begin
                        dev[a[7:0]] = b[15:8];
                        r.dp = a[7:0] + 8'd1;
                     end else begin
                        r.dp = a[7:0];
                     end
                     r.db = b[7:0];
                     dev[r.dp] = r.db;
                     r.dv = 1;
                  end
                  OP_ADD: push_val(src, b + a, sm);
                  OP_SUB: push_val(src, b - a, sm);
                  OP_MUL: push_val(src, b * a, sm);
                  OP_DIV: push_val(src, a != 0 ? b / a : 16'd0, sm);
                  OP_AND: push_val(src, b & a, sm);
                  OP_ORA: push_val(src, b | a, sm);
                  OP_EOR: push_val(src, b ^ a, sm);
                  default: begin
                     v = {16'd0, b} >> a[3:0];
                     v = (v << a[7:4]) & 32'hffff;
                     push_val(src, v[15:0], sm);
                  end
               endcase
            end
         endcase
         pc = p;
      endfunction

      function void note(bit [1:0] t, bit [15:0] loc, bit [7:0] port, bit [7:0] b);
         cpu_result_t r;
         r = '{default: 0};
         case (t)
            REQ_LOAD: mem[loc] = b;
            REQ_DEV:  dev[port] = b;
            REQ_PC: begin
               pc = loc;
               count = 0;
            end
            default: begin
               if (limit != 0 && count >= limit) r.stop = STOP_LIMIT;
               else execute(r);
            end
         endcase
         r.pc = pc;
         awaited.push_back(r);
      endfunction

      function void check(cpu_result_t got);
         cpu_result_t w;
         if (awaited.size() == 0) begin
            $error("result with nothing expected, pc %0h", got.pc);
            errors++;
            return;
         end
         w = awaited.pop_front();
         n_checked++;
         if (w.stop == STOP_BRK) n_brk++;
         if (w.stop == STOP_LIMIT) n_limit++;
         if (w.dv) n_dev++;
         if (got.stop != w.stop) begin
            $error("stop_status expected %0h actual %0h", w.stop, got.stop);
            errors++;
         end
         if (got.dv != w.dv) begin
            $error("dev_out_valid expected %0h actual %0h", w.dv, got.dv);
            errors++;
         end
         if (got.dp != w.dp) begin
            $error("dev_out_port expected %0h actual %0h", w.dp, got.dp);
            errors++;
         end
         if (got.db != w.db) begin
            $error("dev_out_byte expected %0h actual %0h", w.db, got.db);
            errors++;
         end
         if (got.pc != w.pc) begin
            $error("next_pc expected %0h actual %0h", w.pc, got.pc);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_type;
   logic [15:0] req_location;
   logic [7:0]  req_port_number, req_byte_in;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_stop_status;
   logic        rsp_dev_out_valid;
   logic [7:0]  rsp_dev_out_port, rsp_dev_out_byte;
   logic [15:0] rsp_next_pc;
   logic        csr_valid, csr_ready;
   logic [31:0] csr_data;

   cpu_scoreboard sb;
   int tx_idle_pct, rx_idle_pct;
   int n_sent;
   bit want_hold;
   int hold_left;

   stack_machine_cpu_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_location(req_location), .req_port_number(req_port_number),
      .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_stop_status(rsp_stop_status),
      .rsp_dev_out_valid(rsp_dev_out_valid), .rsp_dev_out_port(rsp_dev_out_port),
      .rsp_dev_out_byte(rsp_dev_out_byte), .rsp_next_pc(rsp_next_pc),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // run limit, well past the clearing pass and the slowest run
   initial begin
      #2000000;
      $display("stack_machine_cpu_core_tb: done, errors");
      $finish;
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.limit = csr_data;
         if (req_valid && req_ready)
            sb.note(req_type, req_location, req_port_number, req_byte_in);
         if (rsp_valid && rsp_ready)
            sb.check('{rsp_stop_status, rsp_dev_out_valid, rsp_dev_out_port,
                       rsp_dev_out_byte, rsp_next_pc});
      end
   end

   // receiver with random stalls and at most one long hold-off
   always @(negedge clock) begin
      if (want_hold) begin
         want_hold = 0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send(bit [1:0] t, bit [15:0] loc, bit [7:0] port, bit [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= t;
      req_location    <= loc;
      req_port_number <= port;
      req_byte_in     <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic write_limit(bit [31:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every result, then for a step's worth of cycles
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // a short random program with occasional device writes, usually its start pc, then steps through it
   task automatic program_burst();
      bit [15:0] base;
      int len, steps;
      base  = $urandom;
      len   = $urandom_range(4, 12);
      steps = $urandom_range(3, 16);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0)
            send(REQ_DEV, $urandom, $urandom, $urandom);
         send(REQ_LOAD, base + i[15:0], $urandom, $urandom);
      end
      if ($urandom_range(9) != 0) send(REQ_PC, base, $urandom, $urandom);
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(19) == 0)
            send($urandom_range(3), $urandom, $urandom, $urandom);
         else
            send(REQ_STEP, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      bit [7:0] prog [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_LOAD;
      req_location = 0;
      req_port_number = 0;
      req_byte_in = 0;
      csr_valid = 1'b0;
      csr_data = 0;
      rsp_ready = 1'b0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      want_hold = 0;
      hold_left = 0;
      n_sent = 0;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_limit(32'd0);

      // divide by zero, short device write wrapping past port ff, then break
      prog = '{8'h80, 8'h05, 8'h80, 8'h00, 8'h1b, 8'ha0, 8'h12, 8'h34,
               8'h80, 8'hff, 8'h37, 8'h00};
      foreach (prog[i]) send(REQ_LOAD, 16'h0100 + i[15:0], 8'h00, prog[i]);
      send(REQ_DEV, 16'hffff, 8'hff, 8'hff);
      send(REQ_PC, 16'h0100, 8'h00, 8'h00);
      repeat (7) send(REQ_STEP, 16'h0000, 8'h00, 8'h00);
      send(REQ_PC, 16'hffff, 8'h00, 8'h00);
      send(REQ_STEP, 16'hffff, 8'hff, 8'hff);
      drain();

      // limit stop after two steps
      write_limit(32'd2);
      send(REQ_PC, 16'h0100, 8'h00, 8'h00);
      repeat (4) send(REQ_STEP, 16'h0000, 8'h00, 8'h00);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 64 : 0;
         rx_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 21 : 0;
         write_limit((ph == 0) ? 32'd0 : (ph == 1) ? 32'hffffffff : 32'd7);
         while (n_sent < 25 + 345 * (ph + 1)) begin
            if (ph == 2 && n_sent == 25 + 345 * 2 + 40) want_hold = 1;
            program_burst();
         end
         drain();
      end

      $display("run covered %0d requests, %0d results checked", n_sent, sb.n_checked);
      $display("breaks %0d, limit stops %0d, device writes %0d",
               sb.n_brk, sb.n_limit, sb.n_dev);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("stack_machine_cpu_core_tb: done, clean");
      else
         $display("stack_machine_cpu_core_tb: done, errors");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+design
design/smc_pkg.sv
design/stack_machine_cpu_core.sv
bench/stack_machine_cpu_core_tb.sv
